// ===== design/tis_pkg.sv =====
// Package for the triangle isoline segment block: payload types, codes and latencies.
// No dependencies; every module of the block imports it.
`default_nettype none
package tis_pkg;

    localparam int COORD_W = 32;
    localparam int DIV_STEPS = 32;                 // quotient bits
    localparam int LANE_LAT = DIV_STEPS + 2;       // multiply, divide steps, round
    localparam int ORIENT_LAT = 4;
    localparam int LATENCY = 2 + LANE_LAT + ORIENT_LAT;

    localparam logic [1:0] ST_NONE    = 2'd0;
    localparam logic [1:0] ST_SEGMENT = 2'd1;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_MERGE_TOL = 1'b1;

    typedef struct packed {
        logic signed [31:0] vertex_a_x;
        logic signed [31:0] vertex_a_y;
        logic signed [31:0] vertex_b_x;
        logic signed [31:0] vertex_b_y;
        logic signed [31:0] vertex_c_x;
        logic signed [31:0] vertex_c_y;
        logic signed [31:0] level_a;
        logic signed [31:0] level_b;
        logic signed [31:0] level_c;
    } tri_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
    } seg_t;

    // Item data that rides beside the interpolation lanes.
    typedef struct packed {
        logic               ok;
        logic signed [31:0] lone_x;
        logic signed [31:0] lone_y;
    } side_t;

endpackage
`default_nettype wire

// ===== design/tis_lane.sv =====
// One interpolation lane: p0 +/- round(n*m/d), pipelined one quotient bit per stage.
// Depends on tis_pkg.
`default_nettype none
module tis_lane (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic [31:0]        n,
    input  wire logic [31:0]        m,
    input  wire logic [31:0]        d,
    input  wire logic signed [31:0] p0,
    input  wire logic               neg,
    output logic signed [31:0]      coord
);
    import tis_pkg::*;

    logic [31:0]        rem_reg  [DIV_STEPS+1];
    logic [31:0]        low_reg  [DIV_STEPS+1];
    logic [31:0]        quo_reg  [DIV_STEPS+1];
    logic [31:0]        div_reg  [DIV_STEPS+1];
    logic signed [31:0] base_reg [DIV_STEPS+1];
    logic               neg_reg  [DIV_STEPS+1];
    logic [63:0]        prod;
    logic signed [31:0] coord_reg;
    logic [32:0]        rnd_q;
    logic signed [32:0] coord_next;

    assign prod = 64'(n) * 64'(m);

    // Stage zero holds the full product; the quotient is below 2^32 since n <= d.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= prod[63:32];
            low_reg[0]  <= prod[31:0];
            quo_reg[0]  <= '0;
            div_reg[0]  <= d;
            base_reg[0] <= p0;
            neg_reg[0]  <= neg;
        end
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;
        assign trial = {rem_reg[k-1], low_reg[k-1][31]};
        assign ge    = trial >= {1'b0, div_reg[k-1]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? 32'(trial - {1'b0, div_reg[k-1]}) : trial[31:0];
                low_reg[k]  <= {low_reg[k-1][30:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][30:0], ge};
                div_reg[k]  <= div_reg[k-1];
                base_reg[k] <= base_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    // Round half away from p0, then step along the edge.
    always_comb
    begin
        rnd_q = {1'b0, quo_reg[DIV_STEPS]};
        if ({rem_reg[DIV_STEPS], 1'b0} >= {1'b0, div_reg[DIV_STEPS]})
            rnd_q = rnd_q + 33'd1;
        if (neg_reg[DIV_STEPS])
            coord_next = 33'(base_reg[DIV_STEPS]) - $signed(rnd_q);
        else
            coord_next = 33'(base_reg[DIV_STEPS]) + $signed(rnd_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            coord_reg <= coord_next[31:0];
    end

    assign coord = coord_reg;
endmodule
`default_nettype wire

// ===== design/tis_orient.sv =====
// Orientation stages: sign of the cross product about the lone vertex and the final swap.
// Depends on tis_pkg; the last stage is the block's output register.
`default_nettype none
module tis_orient (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire tis_pkg::side_t     side,
    input  wire logic signed [31:0] p0x,
    input  wire logic signed [31:0] p0y,
    input  wire logic signed [31:0] p1x,
    input  wire logic signed [31:0] p1y,
    output tis_pkg::seg_t           seg
);
    import tis_pkg::*;

    logic signed [31:0] pt_reg [3][4];   // p0x p0y p1x p1y per stage
    logic               ok_reg [3];
    logic signed [32:0] dx0_reg, dy0_reg, dx1_reg, dy1_reg;
    logic signed [50:0] a_lo_reg, b_lo_reg;
    logic signed [48:0] a_hi_reg, b_hi_reg;
    logic signed [65:0] a_reg, b_reg;
    seg_t               seg_reg;
    seg_t               seg_next;

    // Stage A: offsets from the lone vertex.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx0_reg <= 33'(p0x) - 33'(side.lone_x);
            dy0_reg <= 33'(p0y) - 33'(side.lone_y);
            dx1_reg <= 33'(p1x) - 33'(side.lone_x);
            dy1_reg <= 33'(p1y) - 33'(side.lone_y);
            pt_reg[0][0] <= p0x;
            pt_reg[0][1] <= p0y;
            pt_reg[0][2] <= p1x;
            pt_reg[0][3] <= p1y;
            ok_reg[0] <= side.ok;
        end
    end

    // Stage B: partial products, 33 by 17 bits for the low halves and 33 by 16 bits for the high.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_lo_reg <= 51'(dx0_reg) * 51'($signed({1'b0, dy1_reg[16:0]}));
            a_hi_reg <= 49'(dx0_reg) * 49'($signed(dy1_reg[32:17]));
            b_lo_reg <= 51'(dy0_reg) * 51'($signed({1'b0, dx1_reg[16:0]}));
            b_hi_reg <= 49'(dy0_reg) * 49'($signed(dx1_reg[32:17]));
            pt_reg[1] <= pt_reg[0];
            ok_reg[1] <= ok_reg[0];
        end
    end

    // Stage C: full products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= (66'(a_hi_reg) <<< 17) + 66'(a_lo_reg);
            b_reg <= (66'(b_hi_reg) <<< 17) + 66'(b_lo_reg);
            pt_reg[2] <= pt_reg[1];
            ok_reg[2] <= ok_reg[1];
        end
    end

    // Stage D: swap when the cross product is negative.
    always_comb
    begin
        seg_next = '0;
        if (ok_reg[2])
        begin
            seg_next.status = ST_SEGMENT;
            if (a_reg < b_reg)
            begin
                seg_next.start_x = pt_reg[2][2];
                seg_next.start_y = pt_reg[2][3];
                seg_next.end_x   = pt_reg[2][0];
                seg_next.end_y   = pt_reg[2][1];
            end
            else
            begin
                seg_next.start_x = pt_reg[2][0];
                seg_next.start_y = pt_reg[2][1];
                seg_next.end_x   = pt_reg[2][2];
                seg_next.end_y   = pt_reg[2][3];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            seg_reg <= seg_next;
    end

    assign seg = seg_reg;
endmodule
`default_nettype wire

// ===== design/triangle_isoline_segment.sv =====
// Depth: 40 register stages (2 setup, 34 lane, 4 orient); a result is offered from the last
// of them. Throughput: one request per cycle unless the output stalls; the 32-step
// pipelined divider in each lane sets depth.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, asynchronous) clears all valid bits and sets both registers to zero.
`default_nettype none
module triangle_isoline_segment (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   in_valid,
    output logic        in_ready,
    input  wire tis_pkg::tri_t in_data,
    output logic        out_valid,
    input  wire logic   out_ready,
    output tis_pkg::seg_t out_data,
    input  wire logic   cfg_valid,
    output logic        cfg_ready,
    input  wire logic   cfg_index,
    input  wire logic [31:0] cfg_data
);
    import tis_pkg::*;

    // Configuration registers. The merge tolerance is stored for completeness: with
    // exact comparisons a triangle never has three crossed edges, so it never applies.
    logic signed [31:0] thr_reg;
    logic [30:0]        merge_tol_reg;

    // One valid bit per pipeline stage; the whole pipe moves together.
    logic [LATENCY-1:0] vld_reg;
    logic               adv;

    tri_t  tri_reg;
    side_t side_reg [LANE_LAT+1];
    logic [31:0]        n_reg   [4];
    logic [31:0]        m_reg   [4];
    logic [31:0]        d_reg   [4];
    logic signed [31:0] p0_reg  [4];
    logic               neg_reg [4];
    logic signed [31:0] lane_out [4];

    logic signed [31:0] vx [3];
    logic signed [31:0] vy [3];
    logic signed [31:0] lv [3];
    logic [2:0]         up;
    logic [2:0]         crossed;
    logic [1:0]         n_above;
    logic [1:0]         lone;
    logic               two;
    logic [1:0]         e_first, e_second;
    logic [31:0]        n_e [3];
    logic [31:0]        d_e [3];
    logic [31:0]        mx_e [3];
    logic [31:0]        my_e [3];
    logic               nx_e [3];
    logic               ny_e [3];

    assign adv       = !vld_reg[LATENCY-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[LATENCY-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg       <= '0;
            merge_tol_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg <= $signed(cfg_data);
                CFG_MERGE_TOL: merge_tol_reg <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LATENCY-2:0], in_valid};
    end

    // Stage 1: input register.
    always_ff @(posedge clk)
    begin
        if (adv)
            tri_reg <= in_data;
    end

    // Stage 2 logic: classify vertices, pick the two crossed edges and set up the
    // interpolation operands. An edge runs from vertex s to vertex s+1 (mod 3).
    always_comb
    begin
        logic signed [32:0] dlev, dthr, dx, dy;
        vx[0] = tri_reg.vertex_a_x;  vy[0] = tri_reg.vertex_a_y;  lv[0] = tri_reg.level_a;
        vx[1] = tri_reg.vertex_b_x;  vy[1] = tri_reg.vertex_b_y;  lv[1] = tri_reg.level_b;
        vx[2] = tri_reg.vertex_c_x;  vy[2] = tri_reg.vertex_c_y;  lv[2] = tri_reg.level_c;
        for (int k = 0; k < 3; k++)
            up[k] = lv[k] > thr_reg;
        n_above = 2'(up[0]) + 2'(up[1]) + 2'(up[2]);
        lone = 2'd0;
        for (int k = 0; k < 3; k++)
            if (up[k] == (n_above == 2'd1))
                lone = 2'(k);
        for (int e = 0; e < 3; e++)
        begin
            crossed[e] = up[e] != up[(e + 1) % 3];
            dthr = 33'(thr_reg) - 33'(lv[e]);
            dlev = 33'(lv[(e + 1) % 3]) - 33'(lv[e]);
            dx   = 33'(vx[(e + 1) % 3]) - 33'(vx[e]);
            dy   = 33'(vy[(e + 1) % 3]) - 33'(vy[e]);
            n_e[e]  = dthr[32] ? 32'(-dthr) : dthr[31:0];
            d_e[e]  = dlev[32] ? 32'(-dlev) : dlev[31:0];
            mx_e[e] = dx[32] ? 32'(-dx) : dx[31:0];
            my_e[e] = dy[32] ? 32'(-dy) : dy[31:0];
            nx_e[e] = dx[32];
            ny_e[e] = dy[32];
        end
        two      = 2'(crossed[0]) + 2'(crossed[1]) + 2'(crossed[2]) == 2'd2;
        e_first  = crossed[0] ? 2'd0 : 2'd1;
        e_second = crossed[2] ? 2'd2 : 2'd1;
    end

    // Stage 2 registers: lanes 0,1 are x,y of the first crossing, 2,3 of the second.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0] <= n_e[e_first];   d_reg[0] <= d_e[e_first];
            m_reg[0] <= mx_e[e_first];  neg_reg[0] <= nx_e[e_first];
            p0_reg[0] <= vx[e_first];
            n_reg[1] <= n_e[e_first];   d_reg[1] <= d_e[e_first];
            m_reg[1] <= my_e[e_first];  neg_reg[1] <= ny_e[e_first];
            p0_reg[1] <= vy[e_first];
            n_reg[2] <= n_e[e_second];  d_reg[2] <= d_e[e_second];
            m_reg[2] <= mx_e[e_second]; neg_reg[2] <= nx_e[e_second];
            p0_reg[2] <= vx[e_second];
            n_reg[3] <= n_e[e_second];  d_reg[3] <= d_e[e_second];
            m_reg[3] <= my_e[e_second]; neg_reg[3] <= ny_e[e_second];
            p0_reg[3] <= vy[e_second];
            side_reg[0].ok     <= two;
            side_reg[0].lone_x <= vx[lone];
            side_reg[0].lone_y <= vy[lone];
        end
    end

    // Side data follows the lanes through their whole depth.
    for (genvar k = 1; k <= LANE_LAT; k++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[k] <= side_reg[k-1];
        end
    end

    for (genvar l = 0; l < 4; l++)
    begin : g_lane
        tis_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .n     (n_reg[l]),
            .m     (m_reg[l]),
            .d     (d_reg[l]),
            .p0    (p0_reg[l]),
            .neg   (neg_reg[l]),
            .coord (lane_out[l])
        );
    end

    tis_orient u_orient (
        .clk  (clk),
        .en   (adv),
        .side (side_reg[LANE_LAT]),
        .p0x  (lane_out[0]),
        .p0y  (lane_out[1]),
        .p1x  (lane_out[2]),
        .p1y  (lane_out[3]),
        .seg  (out_data)
    );

    // A result either has no segment with zero coordinates or is a valid segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_NONE || out_data.status == ST_SEGMENT))
        else $error("unexpected status code");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_NONE |->
            out_data.start_x == 0 && out_data.start_y == 0 &&
            out_data.end_x == 0 && out_data.end_y == 0)
        else $error("empty result carries coordinates");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(vld_reg) && $stable(out_data))
        else $error("pipeline moved during a stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == CFG_MERGE_TOL |=> merge_tol_reg == $past(cfg_data[30:0]))
        else $error("merge tolerance write lost");
endmodule
`default_nettype wire
